// ----- sv/accel_tilt_pitch_roll_core_assert.svh -----
// ----------------------------------------------------------------------------
// Tilt core assertion macros
// Shared property macros for the tilt core checkers. They sample on clk and
// are held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_PITCH_ROLL_CORE_ASSERT_SVH
`define ACCEL_TILT_PITCH_ROLL_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tilt core check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ATPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tilt core check failed one cycle later");

`endif

// ----- sv/atpr_pkg.sv -----
// ----------------------------------------------------------------------------
// Tilt core package
// Widths, the arctangent table, the word types that move along the cell
// chains, and the per-lane step functions of the root and rotation cells.
// ----------------------------------------------------------------------------
package atpr_pkg;

    // Field widths.
    localparam int AXIS_W    = 16;
    localparam int ANGLE_W   = 15;

    // Sum of two squares, and the numerator scale of 2^15.
    localparam int SQ_W      = 2 * AXIS_W;
    localparam int NUM_SHIFT = 15;

    // The root of (sum << 2*NUM_SHIFT) has one bit per root cell.
    localparam int ROOT_W    = SQ_W / 2 + NUM_SHIFT;
    localparam int REM_W     = ROOT_W + 3;

    // Rotation vector and angle accumulator (units of 2^-16 degree).
    localparam int VEC_W     = ROOT_W + 3;
    localparam int ACC_W     = 25;
    localparam int FRAC_W    = 16;

    // Rotation stage count, capped by the table depth.
    localparam int CORDIC_STAGES = 16;
    localparam int MAX_TABLE     = 32;
    localparam int RUN_STAGES    = (CORDIC_STAGES > MAX_TABLE) ? MAX_TABLE : CORDIC_STAGES;
    localparam int STAGE_IDX_W   = $clog2(MAX_TABLE);

    // Output scaling to hundredths of a degree.
    localparam int CD_PER_DEG = 100;
    localparam int PROD_W     = ACC_W + $clog2(CD_PER_DEG);
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);
    localparam int LIMIT_CD   = 9000;
    localparam logic signed [ANGLE_W-1:0] CD_MAX = ANGLE_W'(LIMIT_CD);
    localparam logic signed [ANGLE_W-1:0] CD_MIN = ANGLE_W'(-LIMIT_CD);

    // atan(2^-i) in degrees times 2^16, rounded to nearest.
    localparam int ATAN_Q16 [MAX_TABLE] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    // One lane of the square root chain.
    typedef struct packed {
        logic [SQ_W-1:0]          rad;
        logic [REM_W-1:0]         rem;
        logic [ROOT_W-1:0]        root;
        logic signed [AXIS_W-1:0] axis;
    } root_lane_t;

    typedef struct packed {
        root_lane_t pitch;
        root_lane_t roll;
        logic       zero;
    } root_word_t;

    // One lane of the rotation chain.
    typedef struct packed {
        logic signed [VEC_W-1:0]   num;
        logic signed [VEC_W-1:0]   den;
        logic signed [ACC_W-1:0]   acc;
        logic                      pinned;
        logic signed [ANGLE_W-1:0] pinned_cd;
    } tilt_lane_t;

    typedef struct packed {
        tilt_lane_t pitch;
        tilt_lane_t roll;
        logic       zero;
    } tilt_word_t;

    // One digit of the restoring square root: two radicand bits in, one
    // root bit out.
    function automatic root_lane_t sqrt_step(root_lane_t l);
        root_lane_t       r;
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        r     = l;
        cur   = {l.rem[REM_W-3:0], l.rad[SQ_W-1 -: 2]};
        trial = {{(REM_W-ROOT_W-2){1'b0}}, l.root, 2'b01};
        r.rad = {l.rad[SQ_W-3:0], 2'b00};
        if (cur >= trial)
        begin
            r.rem  = cur - trial;
            r.root = {l.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = cur;
            r.root = {l.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // Load a lane into the rotation chain and settle the special cases:
    // a zero denominator pins the angle to the sign of the numerator, and a
    // zero numerator pins it to zero.
    function automatic tilt_lane_t tilt_entry(root_lane_t l);
        tilt_lane_t t;
        t.num = {{(VEC_W-AXIS_W-NUM_SHIFT){l.axis[AXIS_W-1]}}, l.axis, {NUM_SHIFT{1'b0}}};
        t.den = {{(VEC_W-ROOT_W){1'b0}}, l.root};
        t.acc = '0;
        t.pinned    = 1'b0;
        t.pinned_cd = '0;
        if (l.root == '0)
        begin
            t.pinned = 1'b1;
            if (l.axis[AXIS_W-1])
                t.pinned_cd = CD_MIN;
            else if (l.axis != '0)
                t.pinned_cd = CD_MAX;
        end
        else if (l.axis == '0)
        begin
            t.pinned = 1'b1;
        end
        return t;
    endfunction

    function automatic tilt_word_t tilt_start(root_word_t w);
        tilt_word_t t;
        t.pitch = tilt_entry(w.pitch);
        t.roll  = tilt_entry(w.roll);
        t.zero  = w.zero;
        return t;
    endfunction

    // One vectoring rotation; shifts round toward minus infinity.
    function automatic tilt_lane_t cordic_step(tilt_lane_t l, logic [STAGE_IDX_W-1:0] idx);
        tilt_lane_t              r;
        logic signed [VEC_W-1:0] dx;
        logic signed [VEC_W-1:0] dy;
        logic signed [ACC_W-1:0] ang;
        r   = l;
        dx  = l.num >>> idx;
        dy  = l.den >>> idx;
        ang = ACC_W'(ATAN_Q16[idx]);
        if (!l.num[VEC_W-1])
        begin
            r.den = l.den + dx;
            r.num = l.num - dy;
            r.acc = l.acc + ang;
        end
        else
        begin
            r.den = l.den - dx;
            r.num = l.num + dy;
            r.acc = l.acc - ang;
        end
        return r;
    endfunction

endpackage

// ----- sv/atpr_square_stage.sv -----
// ----------------------------------------------------------------------------
// Tilt core square stage
// Squares the three axes, forms the two sums of squares that feed the root
// chain, and flags an all-zero sample.
// ----------------------------------------------------------------------------
module atpr_square_stage (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                up_valid,
    output logic                                up_ready,
    input  logic signed [atpr_pkg::AXIS_W-1:0]  accel_x,
    input  logic signed [atpr_pkg::AXIS_W-1:0]  accel_y,
    input  logic signed [atpr_pkg::AXIS_W-1:0]  accel_z,
    output logic                                dn_valid,
    input  logic                                dn_ready,
    output atpr_pkg::root_word_t                dn_word
);

    logic                                     valid_reg;
    logic                                     valid_next;
    atpr_pkg::root_word_t                     word_reg;
    atpr_pkg::root_word_t                     word_next;
    logic signed [2*atpr_pkg::AXIS_W-1:0]     xx;
    logic signed [2*atpr_pkg::AXIS_W-1:0]     yy;
    logic signed [2*atpr_pkg::AXIS_W-1:0]     zz;

    // The stage takes a new word whenever it is empty or its word moves on.
    assign up_ready = !valid_reg || dn_ready;

    // Squares of the three axes.
    always_comb
    begin
        xx = accel_x * accel_x;
        yy = accel_y * accel_y;
        zz = accel_z * accel_z;
    end

    // Next word: pitch uses y and z under the root, roll uses x and z.
    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
            if (up_valid)
            begin
                word_next.pitch.rad  = atpr_pkg::SQ_W'(unsigned'(yy))
                                     + atpr_pkg::SQ_W'(unsigned'(zz));
                word_next.pitch.rem  = '0;
                word_next.pitch.root = '0;
                word_next.pitch.axis = accel_x;
                word_next.roll.rad   = atpr_pkg::SQ_W'(unsigned'(xx))
                                     + atpr_pkg::SQ_W'(unsigned'(zz));
                word_next.roll.rem   = '0;
                word_next.roll.root  = '0;
                word_next.roll.axis  = accel_y;
                word_next.zero       = (accel_x == '0) && (accel_y == '0) && (accel_z == '0);
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

// ----- sv/atpr_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Tilt core square root cell
// One cell of the root chain: resolves one root bit for both lanes and hands
// the word to the next cell.
// ----------------------------------------------------------------------------
module atpr_sqrt_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  atpr_pkg::root_word_t up_word,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output atpr_pkg::root_word_t dn_word
);

    logic                 valid_reg;
    logic                 valid_next;
    atpr_pkg::root_word_t word_reg;
    atpr_pkg::root_word_t word_next;

    // The cell takes a new word whenever it is empty or its word moves on.
    assign up_ready = !valid_reg || dn_ready;

    // One root digit per lane.
    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
            if (up_valid)
            begin
                word_next.pitch = atpr_pkg::sqrt_step(up_word.pitch);
                word_next.roll  = atpr_pkg::sqrt_step(up_word.roll);
                word_next.zero  = up_word.zero;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

// ----- sv/atpr_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// Tilt core rotation cell
// One vectoring CORDIC stage for both lanes. The stage number picks the
// shift and the arctangent table entry.
// ----------------------------------------------------------------------------
module atpr_cordic_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [atpr_pkg::STAGE_IDX_W-1:0]    stage_index,
    input  logic                                up_valid,
    output logic                                up_ready,
    input  atpr_pkg::tilt_word_t                up_word,
    output logic                                dn_valid,
    input  logic                                dn_ready,
    output atpr_pkg::tilt_word_t                dn_word
);

    logic                 valid_reg;
    logic                 valid_next;
    atpr_pkg::tilt_word_t word_reg;
    atpr_pkg::tilt_word_t word_next;

    // The cell takes a new word whenever it is empty or its word moves on.
    assign up_ready = !valid_reg || dn_ready;

    // One rotation per lane toward a zero numerator.
    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
            if (up_valid)
            begin
                word_next.pitch = atpr_pkg::cordic_step(up_word.pitch, stage_index);
                word_next.roll  = atpr_pkg::cordic_step(up_word.roll, stage_index);
                word_next.zero  = up_word.zero;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

// ----- sv/atpr_scale_stage.sv -----
// ----------------------------------------------------------------------------
// Tilt core output stage
// Converts the accumulated angles to rounded, saturated hundredths of a
// degree and holds the result word for the output channel.
// ----------------------------------------------------------------------------
module atpr_scale_stage (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 up_valid,
    output logic                                 up_ready,
    input  atpr_pkg::tilt_word_t                 up_word,
    output logic                                 dn_valid,
    input  logic                                 dn_ready,
    output logic signed [atpr_pkg::ANGLE_W-1:0]  pitch_centideg,
    output logic signed [atpr_pkg::ANGLE_W-1:0]  roll_centideg,
    output logic                                 zero_vector
);

    logic                                valid_reg;
    logic                                valid_next;
    logic signed [atpr_pkg::ANGLE_W-1:0] pitch_reg;
    logic signed [atpr_pkg::ANGLE_W-1:0] pitch_next;
    logic signed [atpr_pkg::ANGLE_W-1:0] roll_reg;
    logic signed [atpr_pkg::ANGLE_W-1:0] roll_next;
    logic                                zero_reg;
    logic                                zero_next;

    // Magnitude times 100 over 2^16, rounded half away from zero, clamped to
    // ninety degrees, then signed. A pinned lane keeps its preset angle.
    function automatic logic signed [atpr_pkg::ANGLE_W-1:0] lane_angle(atpr_pkg::tilt_lane_t l);
        logic [atpr_pkg::ACC_W-1:0]          mag;
        logic [atpr_pkg::PROD_W-1:0]         prod;
        logic [atpr_pkg::PROD_W-1:0]         cd_mag;
        logic signed [atpr_pkg::ANGLE_W-1:0] cd_sat;
        logic signed [atpr_pkg::ANGLE_W-1:0] res;
        mag    = l.acc[atpr_pkg::ACC_W-1] ? atpr_pkg::ACC_W'(-l.acc) : atpr_pkg::ACC_W'(l.acc);
        prod   = atpr_pkg::PROD_W'(mag) * atpr_pkg::PROD_W'(atpr_pkg::CD_PER_DEG)
               + atpr_pkg::PROD_W'(atpr_pkg::ROUND_HALF);
        cd_mag = prod >> atpr_pkg::FRAC_W;
        if (cd_mag > atpr_pkg::PROD_W'(atpr_pkg::LIMIT_CD))
            cd_sat = atpr_pkg::CD_MAX;
        else
            cd_sat = atpr_pkg::ANGLE_W'(cd_mag);
        res = l.acc[atpr_pkg::ACC_W-1] ? -cd_sat : cd_sat;
        if (l.pinned)
            res = l.pinned_cd;
        return res;
    endfunction

    // The output register frees as soon as its word is taken.
    assign up_ready = !valid_reg || dn_ready;

    // Next result word; an all-zero sample reports zero angles.
    always_comb
    begin
        valid_next = valid_reg;
        pitch_next = pitch_reg;
        roll_next  = roll_reg;
        zero_next  = zero_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
            if (up_valid)
            begin
                zero_next = up_word.zero;
                if (up_word.zero)
                begin
                    pitch_next = '0;
                    roll_next  = '0;
                end
                else
                begin
                    pitch_next = lane_angle(up_word.pitch);
                    roll_next  = lane_angle(up_word.roll);
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        pitch_reg <= pitch_next;
        roll_reg  <= roll_next;
        zero_reg  <= zero_next;
    end

    assign dn_valid       = valid_reg;
    assign pitch_centideg = pitch_reg;
    assign roll_centideg  = roll_reg;
    assign zero_vector    = zero_reg;

endmodule

// ----- sv/accel_tilt_pitch_roll_core.sv -----
// Pipeline: one square stage, one root cell per root bit (31), one rotation
// cell per CORDIC stage (16 rotation stages), and one output stage.
// Throughput: one sample word per cycle while angle_stall is low; every cell
// holds one word.
// Reset clears only the valid bits of the cells; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Accelerometer tilt core
// Pitch and roll in hundredths of a degree from one three-axis sample,
// through a chain of square root cells and a chain of CORDIC cells.
// ----------------------------------------------------------------------------
module accel_tilt_pitch_roll_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic signed [atpr_pkg::AXIS_W-1:0]   accel_x,
    input  logic signed [atpr_pkg::AXIS_W-1:0]   accel_y,
    input  logic signed [atpr_pkg::AXIS_W-1:0]   accel_z,
    output logic                                 angle_valid,
    input  logic                                 angle_stall,
    output logic signed [atpr_pkg::ANGLE_W-1:0]  pitch_centideg,
    output logic signed [atpr_pkg::ANGLE_W-1:0]  roll_centideg,
    output logic                                 zero_vector
);

    logic                 sample_ready;
    logic                 root_valid [atpr_pkg::ROOT_W+1];
    logic                 root_ready [atpr_pkg::ROOT_W+1];
    atpr_pkg::root_word_t root_word  [atpr_pkg::ROOT_W+1];
    logic                 tilt_valid [atpr_pkg::RUN_STAGES+1];
    logic                 tilt_ready [atpr_pkg::RUN_STAGES+1];
    atpr_pkg::tilt_word_t tilt_word  [atpr_pkg::RUN_STAGES+1];

    assign sample_stall = !sample_ready;

    // Squares and sums of squares.
    atpr_square_stage u_square (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sample_valid),
        .up_ready (sample_ready),
        .accel_x  (accel_x),
        .accel_y  (accel_y),
        .accel_z  (accel_z),
        .dn_valid (root_valid[0]),
        .dn_ready (root_ready[0]),
        .dn_word  (root_word[0])
    );

    // Square root chain, one root bit per cell.
    for (genvar k = 0; k < atpr_pkg::ROOT_W; k++)
    begin : g_root
        atpr_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (root_valid[k]),
            .up_ready (root_ready[k]),
            .up_word  (root_word[k]),
            .dn_valid (root_valid[k+1]),
            .dn_ready (root_ready[k+1]),
            .dn_word  (root_word[k+1])
        );
    end

    // Hand over to the rotation chain, settling the pinned cases.
    assign tilt_valid[0]                    = root_valid[atpr_pkg::ROOT_W];
    assign root_ready[atpr_pkg::ROOT_W]     = tilt_ready[0];
    assign tilt_word[0]                     = atpr_pkg::tilt_start(root_word[atpr_pkg::ROOT_W]);

    // CORDIC vectoring chain, one stage per cell.
    for (genvar k = 0; k < atpr_pkg::RUN_STAGES; k++)
    begin : g_tilt
        atpr_cordic_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .stage_index (atpr_pkg::STAGE_IDX_W'(k)),
            .up_valid    (tilt_valid[k]),
            .up_ready    (tilt_ready[k]),
            .up_word     (tilt_word[k]),
            .dn_valid    (tilt_valid[k+1]),
            .dn_ready    (tilt_ready[k+1]),
            .dn_word     (tilt_word[k+1])
        );
    end

    // Scaling and the output register.
    atpr_scale_stage u_scale (
        .clk            (clk),
        .rst_n          (rst_n),
        .up_valid       (tilt_valid[atpr_pkg::RUN_STAGES]),
        .up_ready       (tilt_ready[atpr_pkg::RUN_STAGES]),
        .up_word        (tilt_word[atpr_pkg::RUN_STAGES]),
        .dn_valid       (angle_valid),
        .dn_ready       (!angle_stall),
        .pitch_centideg (pitch_centideg),
        .roll_centideg  (roll_centideg),
        .zero_vector    (zero_vector)
    );

endmodule

// ----- sv/atpr_checker.sv -----
// ----------------------------------------------------------------------------
// Tilt core port checker
// Watches the ports of the tilt core: angle range, the all-zero word,
// back-pressure, and the stalled output word.
// ----------------------------------------------------------------------------
`include "accel_tilt_pitch_roll_core_assert.svh"

module atpr_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 sample_stall,
    input logic                                 angle_valid,
    input logic                                 angle_stall,
    input logic signed [atpr_pkg::ANGLE_W-1:0]  pitch_centideg,
    input logic signed [atpr_pkg::ANGLE_W-1:0]  roll_centideg,
    input logic                                 zero_vector
);

    // Both angles stay within plus or minus ninety degrees.
    `ATPR_ASSERT_NOW(a_angle_range, angle_valid, (pitch_centideg <= atpr_pkg::CD_MAX) && (pitch_centideg >= atpr_pkg::CD_MIN) && (roll_centideg <= atpr_pkg::CD_MAX) && (roll_centideg >= atpr_pkg::CD_MIN))

    // An all-zero sample reports zero angles.
    `ATPR_ASSERT_NOW(a_zero_angles, angle_valid && zero_vector, (pitch_centideg == '0) && (roll_centideg == '0))

    // The input side only backs up when a finished word is held at the output.
    `ATPR_ASSERT_NOW(a_stall_source, sample_stall, angle_valid && angle_stall)

    // A stalled result word holds.
    `ATPR_ASSERT_NEXT(a_out_hold, angle_valid && angle_stall, angle_valid && $stable(pitch_centideg) && $stable(roll_centideg) && $stable(zero_vector))

endmodule

bind accel_tilt_pitch_roll_core atpr_checker u_atpr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_stall   (sample_stall),
    .angle_valid    (angle_valid),
    .angle_stall    (angle_stall),
    .pitch_centideg (pitch_centideg),
    .roll_centideg  (roll_centideg),
    .zero_vector    (zero_vector)
);
